// ----- hdl/hdd_pkg.sv -----
// Shared types and constants of the height-drop fall detector.
// No dependencies; every other file imports this package.
package hdd_pkg;

  localparam int HEIGHT_W = 16;
  localparam int TIME_W   = 48;
  localparam int LEVEL_W  = 13;
  localparam int COUNT_W  = 8;
  localparam int SPAN_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Accepted height range: MIN_HEIGHT_MM < h <= MAX_HEIGHT_MM
  localparam logic signed [HEIGHT_W-1:0] MIN_HEIGHT_MM = 16'sd50;
  localparam logic signed [HEIGHT_W-1:0] MAX_HEIGHT_MM = 16'sd8000;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LEVEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LEVEL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_COUNT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN     = 3'd5;

  // Reset values of the registers
  localparam logic [LEVEL_W-1:0] RST_HIGH_LEVEL = 13'd1000;
  localparam logic [LEVEL_W-1:0] RST_LOW_LEVEL  = 13'd500;
  localparam logic [COUNT_W-1:0] RST_HIGH_COUNT = 8'd3;
  localparam logic [COUNT_W-1:0] RST_LOW_COUNT  = 8'd3;
  localparam logic [SPAN_W-1:0]  RST_WINDOW     = 32'd1500000;
  localparam logic [SPAN_W-1:0]  RST_COOLDOWN   = 32'd10000000;

  typedef struct packed {
    logic [LEVEL_W-1:0] high_level_mm;
    logic [LEVEL_W-1:0] low_level_mm;
    logic [COUNT_W-1:0] high_count_needed;
    logic [COUNT_W-1:0] low_count_needed;
    logic [SPAN_W-1:0]  window_us;
    logic [SPAN_W-1:0]  fall_gap_us;
  } hdd_cfg_t;

endpackage

// ----- hdl/hdd_if.sv -----
// Handshake channels of the fall detector: sample input, result output
// and configuration write. Depends on hdd_pkg.
interface hdd_in_if;
  import hdd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [HEIGHT_W-1:0] height_mm;
  logic [TIME_W-1:0]          time_us;
  modport source (output valid, output height_mm, output time_us, input ready);
  modport sink   (input valid, input height_mm, input time_us, output ready);
endinterface

interface hdd_out_if;
  logic valid;
  logic ready;
  logic fall_event;
  logic is_standing;
  logic sample_used;
  modport source (output valid, output fall_event, output is_standing,
                  output sample_used, input ready);
  modport sink   (input valid, input fall_event, input is_standing,
                  input sample_used, output ready);
endinterface

interface hdd_cfg_if;
  import hdd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/hdd_cfg_regs.sv -----
// Configuration register file of the fall detector.
// Depends on hdd_pkg and hdd_cfg_if.
module hdd_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  hdd_cfg_if.sink          cfg_ch,
  output hdd_pkg::hdd_cfg_t cfg
);
  import hdd_pkg::*;

  hdd_cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_level_mm     <= RST_HIGH_LEVEL;
      cfg_r.low_level_mm      <= RST_LOW_LEVEL;
      cfg_r.high_count_needed <= RST_HIGH_COUNT;
      cfg_r.low_count_needed  <= RST_LOW_COUNT;
      cfg_r.window_us         <= RST_WINDOW;
      cfg_r.fall_gap_us       <= RST_COOLDOWN;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_HIGH_LEVEL: cfg_r.high_level_mm     <= cfg_ch.data[LEVEL_W-1:0];
        CFG_LOW_LEVEL:  cfg_r.low_level_mm      <= cfg_ch.data[LEVEL_W-1:0];
        CFG_HIGH_COUNT: cfg_r.high_count_needed <= cfg_ch.data[COUNT_W-1:0];
        CFG_LOW_COUNT:  cfg_r.low_count_needed  <= cfg_ch.data[COUNT_W-1:0];
        CFG_WINDOW:     cfg_r.window_us         <= cfg_ch.data[SPAN_W-1:0];
        CFG_COOLDOWN:   cfg_r.fall_gap_us       <= cfg_ch.data[SPAN_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

endmodule

// ----- hdl/hdd_core.sv -----
// Sample pipeline of the fall detector: input register, posture state,
// update logic and result register. Depends on hdd_pkg and hdd_if.
module hdd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  hdd_pkg::hdd_cfg_t cfg,
  hdd_in_if.sink            in_ch,
  hdd_out_if.source         out_ch
);
  import hdd_pkg::*;

  // input register
  logic                       s1_v_r;
  logic signed [HEIGHT_W-1:0] s1_h_r;
  logic [TIME_W-1:0]          s1_t_r;

  // posture state
  logic               standing_r, standing_nxt;
  logic [COUNT_W-1:0] high_run_r, high_run_nxt;
  logic [COUNT_W-1:0] low_run_r, low_run_nxt;
  logic [TIME_W-1:0]  posture_time_r, posture_time_nxt;
  logic [TIME_W-1:0]  last_fall_r, last_fall_nxt;

  // result register
  logic o_v_r, o_fall_r, o_stand_r, o_used_r;
  logic fall_nxt, used;

  logic advance;

  logic [TIME_W-1:0]  dt_posture, dt_fall, window_ext, cooldown_ext;
  logic               timeout, is_high, is_low;
  logic               st0;
  logic [COUNT_W-1:0] hr0, lr0, hr_inc, lr_inc;

  assign advance      = s1_v_r && (!o_v_r || out_ch.ready);
  assign in_ch.ready  = !s1_v_r || advance;

  assign out_ch.valid       = o_v_r;
  assign out_ch.fall_event  = o_fall_r;
  assign out_ch.is_standing = o_stand_r;
  assign out_ch.sample_used = o_used_r;

  assign window_ext   = {{(TIME_W-SPAN_W){1'b0}}, cfg.window_us};
  assign cooldown_ext = {{(TIME_W-SPAN_W){1'b0}}, cfg.fall_gap_us};
  assign dt_posture   = s1_t_r - posture_time_r;
  assign dt_fall      = s1_t_r - last_fall_r;

  assign used    = (s1_h_r > MIN_HEIGHT_MM) && (s1_h_r <= MAX_HEIGHT_MM);
  // within the accepted range the height fits the level width
  assign is_high = s1_h_r[LEVEL_W-1:0] >= cfg.high_level_mm;
  assign is_low  = s1_h_r[LEVEL_W-1:0] <= cfg.low_level_mm;

  assign timeout = standing_r && (dt_posture > window_ext);
  assign st0     = standing_r && !timeout;
  assign hr0     = timeout ? '0 : high_run_r;
  assign lr0     = timeout ? '0 : low_run_r;
  assign hr_inc  = (hr0 == COUNT_MAX) ? hr0 : hr0 + COUNT_W'(1);
  assign lr_inc  = (lr0 == COUNT_MAX) ? lr0 : lr0 + COUNT_W'(1);

  always_comb begin
    standing_nxt     = standing_r;
    high_run_nxt     = high_run_r;
    low_run_nxt      = low_run_r;
    posture_time_nxt = posture_time_r;
    last_fall_nxt    = last_fall_r;
    fall_nxt         = 1'b0;
    if (used) begin
      standing_nxt = st0;
      high_run_nxt = hr0;
      low_run_nxt  = lr0;
      if (is_high) begin
        high_run_nxt = hr_inc;
        low_run_nxt  = '0;
        if (st0 || (hr_inc >= cfg.high_count_needed)) begin
          standing_nxt     = 1'b1;
          posture_time_nxt = s1_t_r;
        end
      end else if (st0) begin
        if (is_low) begin
          low_run_nxt = lr_inc;
          if (lr_inc >= cfg.low_count_needed) begin
            // report only inside the window and past the cooldown
            if ((dt_posture <= window_ext) && (dt_fall >= cooldown_ext)) begin
              fall_nxt      = 1'b1;
              last_fall_nxt = s1_t_r;
            end
            standing_nxt = 1'b0;
            high_run_nxt = '0;
            low_run_nxt  = '0;
          end
        end else begin
          low_run_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r         <= 1'b0;
      o_v_r          <= 1'b0;
      standing_r     <= 1'b0;
      high_run_r     <= '0;
      low_run_r      <= '0;
      posture_time_r <= '0;
      last_fall_r    <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        s1_v_r <= 1'b1;
      end else if (advance) begin
        s1_v_r <= 1'b0;
      end
      if (advance) begin
        o_v_r          <= 1'b1;
        standing_r     <= standing_nxt;
        high_run_r     <= high_run_nxt;
        low_run_r      <= low_run_nxt;
        posture_time_r <= posture_time_nxt;
        last_fall_r    <= last_fall_nxt;
      end else if (out_ch.ready) begin
        o_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_h_r <= in_ch.height_mm;
      s1_t_r <= in_ch.time_us;
    end
    if (advance) begin
      o_fall_r  <= fall_nxt;
      o_stand_r <= standing_nxt;
      o_used_r  <= used;
    end
  end

endmodule

// ----- hdl/height_drop_fall_detector.sv -----
// Fall detector on tracked-target height samples: top level.
// Depends on hdd_pkg, hdd_if, hdd_cfg_regs and hdd_core.
//
// Usage:
//   in_ch  - sample words (height_mm, signed mm; time_us, 48-bit wrapping
//            microsecond stamp), taken when valid and ready are both high.
//   out_ch - one result word per sample: fall_event, is_standing and
//            sample_used, in sample order.
//   cfg_ch - register writes (index, data); always ready. Write only while
//            no sample is in flight. Unknown indexes are dropped.
// A sample passes through one input register, then the posture update feeding
// the result register. One sample is taken every cycle while the receiver
// does not stall; the posture state updates as each sample moves into the
// result register, so the next sample sees it without a bubble.
// When the receiver stalls, the result register holds its word and the
// input register holds one more sample; ready then drops until the
// result is taken.
// Reset (synchronous, rst_n low) empties both registers, clears the
// standing flag, run counters and timestamps, and reloads the register
// defaults.
module height_drop_fall_detector (
  input  logic      clk,
  input  logic      rst_n,
  hdd_in_if.sink    in_ch,
  hdd_out_if.source out_ch,
  hdd_cfg_if.sink   cfg_ch
);
  import hdd_pkg::*;

  // live register values; the user keeps them stable while samples flow, the block does not enforce it
  hdd_cfg_t cfg;

  hdd_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // sample pipeline and posture state
  hdd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
